FILE: rtl/modbus_rtu_request_framer_defines.svh
// Assertion macros for the Modbus RTU request framer RTL.
// No dependencies; included by the modules that carry assertions.
`ifndef MODBUS_RTU_REQUEST_FRAMER_DEFINES_SVH
`define MODBUS_RTU_REQUEST_FRAMER_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define MRF_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define MRF_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/mrf_pkg.sv
// Types, constants and the CRC-16/MODBUS byte update for the request framer.
// No dependencies.
package mrf_pkg;

    localparam int BODY_BYTES  = 6;
    localparam int FRAME_BYTES = 8;
    localparam int POS_W       = 3;

    localparam logic [15:0]      CRC_INIT = 16'hFFFF;
    localparam logic [15:0]      CRC_POLY = 16'hA001;
    localparam logic [POS_W-1:0] LAST_POS = 3'd7;

    // one request on its way through the CRC pipe
    typedef struct packed {
        logic [BODY_BYTES-1:0][7:0] body;   // body[0] is frame byte 0
        logic [15:0]                crc;
    } mrf_item_t;

    // reflected CRC over one byte, LSB first
    function automatic logic [15:0] crc_byte(input logic [15:0] crc_in,
                                             input logic [7:0]  b);
        logic [15:0] c;
        c = crc_in ^ {8'h00, b};
        for (int k = 0; k < 8; k++) begin
            if (c[0])
                c = (c >> 1) ^ CRC_POLY;
            else
                c = c >> 1;
        end
        return c;
    endfunction

endpackage

FILE: rtl/modbus_rtu_request_framer.sv
// Top level of the Modbus RTU request framer: CRC pipe plus byte serializer.
// Depends on mrf_pkg, mrf_crc_stage and mrf_serializer.
//
// Usage
//   Slave side: one item per request. s_axis_tdata carries slave_addr,
//   func_code, start_reg and reg_count. Master side: eight items per
//   request, the frame bytes in wire order: slave, function, start hi/lo,
//   count hi/lo, CRC-16/MODBUS lo, CRC hi. tuser gives the byte position,
//   tlast marks the CRC high byte.
//   Pipeline: six CRC stages, one frame byte each, then the serializer;
//   a request is registered in each stage in turn and then loaded into
//   the serializer, whose registers drive the master side.
//   Throughput: set by the serializer, sending one byte per cycle while
//   m_axis_tready is high. The CRC pipe takes a request every cycle unless
//   stalled, and buffers up to six requests while the serializer is busy.
//   Stall: when tready drops the current byte holds; backpressure runs
//   stage by stage up the pipe to s_axis_tready, nothing is dropped.
//   Reset: rst_n (async, active low) empties every stage; no frame in
//   flight survives it.
module modbus_rtu_request_framer
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [47:0] s_axis_tdata,   // slave_addr[7:0], func_code[15:8],
                                        // start_reg[31:16], reg_count[47:32]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,   // frame_byte[7:0]
    output logic [2:0]  m_axis_tuser,   // byte_pos[2:0]
    output logic        m_axis_tlast    // last_byte
);

    localparam int NSTG = mrf_pkg::BODY_BYTES;

    mrf_pkg::mrf_item_t stg_item  [0:NSTG];
    logic               stg_valid [0:NSTG];
    logic               stg_ready [0:NSTG];

    // frame body in wire order; 16-bit fields go big-endian
    always_comb
    begin
        stg_item[0].body[0] = s_axis_tdata[7:0];
        stg_item[0].body[1] = s_axis_tdata[15:8];
        stg_item[0].body[2] = s_axis_tdata[31:24];
        stg_item[0].body[3] = s_axis_tdata[23:16];
        stg_item[0].body[4] = s_axis_tdata[47:40];
        stg_item[0].body[5] = s_axis_tdata[39:32];
        stg_item[0].crc     = mrf_pkg::CRC_INIT;
    end

    assign stg_valid[0]  = s_axis_tvalid;
    assign s_axis_tready = stg_ready[0];

    // stage k folds frame byte k into the CRC
    for (genvar k = 0; k < NSTG; k++)
    begin : g_crc
        mrf_crc_stage u_stage
        (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (stg_valid[k]),
            .in_ready  (stg_ready[k]),
            .in_item   (stg_item[k]),
            .in_byte   (stg_item[k].body[k]),
            .out_valid (stg_valid[k+1]),
            .out_ready (stg_ready[k+1]),
            .out_item  (stg_item[k+1])
        );
    end

    mrf_serializer u_ser
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (stg_valid[NSTG]),
        .in_ready      (stg_ready[NSTG]),
        .in_item       (stg_item[NSTG]),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

endmodule

FILE: rtl/mrf_crc_stage.sv
// One CRC pipeline stage: folds one frame byte into the running CRC.
// Depends on mrf_pkg.
module mrf_crc_stage
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  mrf_pkg::mrf_item_t in_item,
    input  logic [7:0]        in_byte,
    output logic              out_valid,
    input  logic              out_ready,
    output mrf_pkg::mrf_item_t out_item
);

    logic               valid_reg;
    logic               valid_next;
    mrf_pkg::mrf_item_t item_reg;
    mrf_pkg::mrf_item_t item_next;

    assign in_ready = !valid_reg || out_ready;

    always_comb
    begin
        valid_next = valid_reg;
        item_next  = item_reg;
        if (in_ready)
        begin
            valid_next = in_valid;
            if (in_valid)
            begin
                item_next.body = in_item.body;
                item_next.crc  = mrf_pkg::crc_byte(in_item.crc, in_byte);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        item_reg <= item_next;
    end

    assign out_valid = valid_reg;
    assign out_item  = item_reg;

endmodule

FILE: rtl/mrf_serializer.sv
// Output stage: holds one finished frame and sends it one byte per item.
// Depends on mrf_pkg and modbus_rtu_request_framer_defines.svh.
`include "modbus_rtu_request_framer_defines.svh"

module mrf_serializer
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    output logic                      in_ready,
    input  mrf_pkg::mrf_item_t         in_item,
    output logic                      m_axis_tvalid,
    input  logic                      m_axis_tready,
    output logic [7:0]                m_axis_tdata,
    output logic [mrf_pkg::POS_W-1:0] m_axis_tuser,
    output logic                      m_axis_tlast
);

    logic                                    valid_reg;
    logic                                    valid_next;
    logic [mrf_pkg::POS_W-1:0]               cnt_reg;
    logic [mrf_pkg::POS_W-1:0]               cnt_next;
    logic [mrf_pkg::FRAME_BYTES-1:0][7:0]    frame_reg;
    logic [mrf_pkg::FRAME_BYTES-1:0][7:0]    frame_next;
    logic                                    out_fire;
    logic                                    at_end;

    assign out_fire = valid_reg && m_axis_tready;
    assign at_end   = (cnt_reg == mrf_pkg::LAST_POS);
    // next frame loads as the last byte of the current one leaves
    assign in_ready = !valid_reg || (out_fire && at_end);

    always_comb
    begin
        valid_next = valid_reg;
        cnt_next   = cnt_reg;
        frame_next = frame_reg;
        if (in_valid && in_ready)
        begin
            valid_next = 1'b1;
            cnt_next   = '0;
            frame_next = {in_item.crc[15:8], in_item.crc[7:0], in_item.body};
        end
        else if (out_fire)
        begin
            if (at_end)
                valid_next = 1'b0;
            cnt_next = cnt_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            cnt_reg   <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        frame_reg <= frame_next;
    end

    assign m_axis_tvalid = valid_reg;
    assign m_axis_tdata  = frame_reg[cnt_reg];
    assign m_axis_tuser  = cnt_reg;
    assign m_axis_tlast  = at_end;

    `MRF_ASSERT_NOW(a_last_on_crc_high, m_axis_tvalid, m_axis_tlast == (m_axis_tuser == mrf_pkg::LAST_POS), "tlast not on final byte")
    `MRF_ASSERT_NEXT(a_pos_advances, out_fire && !at_end, valid_reg && (cnt_reg == $past(cnt_reg) + 1'b1), "byte position did not advance")
    `MRF_ASSERT_NEXT(a_load_starts_frame, in_valid && in_ready, valid_reg && (cnt_reg == '0), "new frame did not start at byte zero")

endmodule
